// File: rtl/ssre_pkg.sv
// Shared constants, types and helper functions of the stamp-sum reachability engine.
`timescale 1ns / 1ps
`default_nettype none

package ssre_pkg;

    localparam int MaxStamps = 8;
    localparam int RowBits   = 1024;
    localparam int WordBits  = 64;
    localparam int RowWords  = RowBits / WordBits;
    localparam int NumRows   = MaxStamps + 1;
    localparam int MemDepth  = NumRows * RowWords;
    localparam int AddrW     = 8;

    // Item commands
    localparam logic [1:0] CmdInit = 2'd0;
    localparam logic [1:0] CmdAdd  = 2'd1;
    localparam logic [1:0] CmdTest = 2'd2;
    localparam logic [1:0] CmdPeek = 2'd3;

    // Register indexes
    localparam logic RegStamps = 1'b0;
    localparam logic RegTcount = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXT_RD,
        ST_EXT_WR,
        ST_EXT_DRAIN,
        ST_EXT_RES,
        ST_TST_ISSUE,
        ST_TST_CHECK,
        ST_DONE
    } state_t;

    // Index of the lowest set bit of a word
    function automatic logic [5:0] lowest_set(input logic [WordBits-1:0] w);
        logic [5:0] idx;
        idx = '0;
        for (int b = WordBits - 1; b >= 0; b--)
        begin
            if (w[b])
            begin
                idx = 6'(b);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ssre_ram.sv
// Generic synchronous RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ssre_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 144
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read, read data registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/stamp_sum_reachability_engine_core.sv
// Top level of the stamp-sum reachability engine.
//
// Channel   Dir  Handshake                Contents
// s_*       in   s_tvalid / s_tready      cmd, denomination, first_sum
// m_*       out  m_tvalid / m_tready      range, reachable, truncated
// APB       in   psel & penable & pwrite  stamps at 0x0, tcount at 0x4
//
// Add or peek (nonzero denomination): a read and a write state per word of rows 1..h
// through the read-modify-write on the row memories. Test: per target, at most an issue
// and a check step per count 0..h of the denomination, one memory read each step. Init:
// a clearing pass. After reset and after each stamps write, a clearing pass over all
// 144 words rewrites the row memory while s_tready stays low. One item at a time; a
// finished result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
`default_nettype none

module stamp_sum_reachability_engine_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // cmd[1:0], denomination[11:2], first_sum[21:12]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // range[9:0], reachable[10], truncated[11]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW = ssre_pkg::AddrW;
    localparam int WB = ssre_pkg::WordBits;

    ssre_pkg::state_t state_reg, state_next;

    logic [1:0]  op_cmd_reg, op_cmd_next;
    logic [9:0]  op_a_reg, op_a_next;
    logic [3:0]  stamps_reg, stamps_next;
    logic [6:0]  tcount_reg, tcount_next;
    logic [9:0]  cur_range_reg, cur_range_next;
    logic [12:0] lsum_reg, lsum_next;
    logic [7:0]  clr_cnt_reg, clr_cnt_next;
    logic        clr_reply_reg, clr_reply_next;
    logic [3:0]  d_reg, d_next;
    logic [3:0]  wi_reg, wi_next;
    logic [WB-1:0] prev_reg, prev_next;
    logic        scan_vld_reg, scan_vld_next;
    logic [WB-1:0] scan_word_reg, scan_word_next;
    logic [3:0]  scan_idx_reg, scan_idx_next;
    logic        found_reg, found_next;
    logic [9:0]  found_x_reg, found_x_next;
    logic [10:0] t_reg, t_next;
    logic [6:0]  o_reg, o_next;
    logic [3:0]  c_reg, c_next;
    logic [13:0] ca_reg, ca_next;
    logic        chk_ok_reg, chk_ok_next;
    logic [5:0]  chk_bit_reg, chk_bit_next;
    logic [9:0]  res_range_reg, res_range_next;
    logic        res_reach_reg, res_reach_next;
    logic        res_trunc_reg, res_trunc_next;
    logic        out_vld_reg, out_vld_next;
    logic [9:0]  out_range_reg, out_range_next;
    logic        out_reach_reg, out_reach_next;
    logic        out_trunc_reg, out_trunc_next;

    // Memory ports
    logic          reach_we, work_we;
    logic [AW-1:0] waddr;
    logic [WB-1:0] wdata;
    logic [AW-1:0] dst_raddr, src_raddr;
    logic [WB-1:0] dst_rdata, srcr_rdata, srcw_rdata;

    // Datapath helpers
    logic [13:0] prod_ha;
    logic [10:0] upper;
    logic [10:0] start;
    logic [3:0]  ws;
    logic [5:0]  bs;
    logic [WB-1:0] src_word, shifted, new_word, scan_mask;
    logic [3:0]  dt;
    logic [13:0] r_val;
    logic [16:0] bound;
    logic        cfg_wr;
    logic [3:0]  stamps_wr;
    logic        in_acc;
    logic [11:0] x_pos;

    // Row memory, two copies for two reads a cycle, plus a scratch copy for peeks
    ssre_ram #(.WIDTH(WB), .DEPTH(ssre_pkg::MemDepth)) u_reach_dst (
        .clk(clk), .we(reach_we), .waddr(waddr), .wdata(wdata),
        .raddr(dst_raddr), .rdata(dst_rdata)
    );

    ssre_ram #(.WIDTH(WB), .DEPTH(ssre_pkg::MemDepth)) u_reach_src (
        .clk(clk), .we(reach_we), .waddr(waddr), .wdata(wdata),
        .raddr(src_raddr), .rdata(srcr_rdata)
    );

    ssre_ram #(.WIDTH(WB), .DEPTH(ssre_pkg::MemDepth)) u_work (
        .clk(clk), .we(work_we), .waddr(waddr), .wdata(wdata),
        .raddr(src_raddr), .rdata(srcw_rdata)
    );

    // Ports
    assign s_tready = (state_reg == ssre_pkg::ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'b0, out_trunc_reg, out_reach_reg, out_range_reg};
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == ssre_pkg::RegTcount) ? {25'b0, tcount_reg}
                                                        : {28'b0, stamps_reg};
    assign cfg_wr   = psel && penable && pwrite && pready;

    // Clamp the stamps value
    always_comb
    begin
        if (pwdata[3:0] == 4'd0)
        begin
            stamps_wr = 4'd1;
        end
        else if (pwdata[3:0] > 4'(ssre_pkg::MaxStamps))
        begin
            stamps_wr = 4'(ssre_pkg::MaxStamps);
        end
        else
        begin
            stamps_wr = pwdata[3:0];
        end
    end

    // Sum bounds for add and peek
    assign prod_ha = 14'(stamps_reg) * 14'(op_a_reg);
    assign upper   = (prod_ha >= 14'(ssre_pkg::RowBits)) ? 11'(ssre_pkg::RowBits)
                                                         : 11'(prod_ha + 14'd1);
    assign start   = 11'(cur_range_reg) + 11'd1;
    assign ws      = op_a_reg[9:6];
    assign bs      = op_a_reg[5:0];

    // Shift the previous row word by word
    always_comb
    begin
        src_word = ((op_cmd_reg == ssre_pkg::CmdPeek) && (d_reg >= 4'd2)) ? srcw_rdata
                                                                          : srcr_rdata;
        shifted = '0;
        if (wi_reg >= ws)
        begin
            shifted = src_word << bs;
        end
        if ((wi_reg > ws) && (bs != 6'd0))
        begin
            shifted = shifted | (prev_reg >> (7'd64 - 7'(bs)));
        end
        new_word = dst_rdata | shifted;
    end

    // Window of bits that the range search looks at in this word
    always_comb
    begin
        for (int b = 0; b < WB; b++)
        begin
            x_pos = {2'b0, wi_reg, 6'(b)};
            scan_mask[b] = (x_pos >= 12'(start)) && (x_pos < 12'(upper));
        end
    end

    // Reach test step
    assign dt    = stamps_reg - c_reg;
    assign r_val = 14'(t_reg) - ca_reg;
    assign bound = (c_reg == 4'd0) ? 17'(lsum_reg) : 17'(dt) * 17'(lsum_reg);

    // Memory addresses and writes
    always_comb
    begin
        reach_we  = 1'b0;
        work_we   = 1'b0;
        waddr     = {d_reg, wi_reg};
        wdata     = new_word;
        dst_raddr = {d_reg, wi_reg};
        src_raddr = {d_reg - 4'd1, wi_reg - ws};
        case (state_reg)
            ssre_pkg::ST_CLEAR:
            begin
                reach_we = 1'b1;
                waddr    = clr_cnt_reg;
                wdata    = ((clr_cnt_reg[3:0] == 4'd0) && (clr_cnt_reg[7:4] <= stamps_reg))
                           ? ((64'd2 << clr_cnt_reg[7:4]) - 64'd1) : '0;
            end
            ssre_pkg::ST_EXT_WR:
            begin
                reach_we = (op_cmd_reg == ssre_pkg::CmdAdd);
                work_we  = (op_cmd_reg == ssre_pkg::CmdPeek);
            end
            ssre_pkg::ST_TST_ISSUE:
            begin
                dst_raddr = {dt, r_val[9:6]};
            end
            default:
            begin
            end
        endcase
    end

    // Control and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        op_cmd_next    = op_cmd_reg;
        op_a_next      = op_a_reg;
        stamps_next    = stamps_reg;
        tcount_next    = tcount_reg;
        cur_range_next = cur_range_reg;
        lsum_next      = lsum_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_reply_next = clr_reply_reg;
        d_next         = d_reg;
        wi_next        = wi_reg;
        prev_next      = prev_reg;
        scan_vld_next  = 1'b0;
        scan_word_next = scan_word_reg;
        scan_idx_next  = scan_idx_reg;
        found_next     = found_reg;
        found_x_next   = found_x_reg;
        t_next         = t_reg;
        o_next         = o_reg;
        c_next         = c_reg;
        ca_next        = ca_reg;
        chk_ok_next    = chk_ok_reg;
        chk_bit_next   = chk_bit_reg;
        res_range_next = res_range_reg;
        res_reach_next = res_reach_reg;
        res_trunc_next = res_trunc_reg;
        out_vld_next   = out_vld_reg && !m_tready;
        out_range_next = out_range_reg;
        out_reach_next = out_reach_reg;
        out_trunc_next = out_trunc_reg;

        // Take the first unset bit of the last row
        if (scan_vld_reg && !found_reg && (scan_word_reg != '0))
        begin
            found_next   = 1'b1;
            found_x_next = {scan_idx_reg, ssre_pkg::lowest_set(scan_word_reg)};
        end

        case (state_reg)
            ssre_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 8'd1;
                if (clr_cnt_reg == 8'(ssre_pkg::MemDepth - 1))
                begin
                    res_range_next = cur_range_reg;
                    res_reach_next = 1'b0;
                    res_trunc_next = 1'b0;
                    state_next     = clr_reply_reg ? ssre_pkg::ST_DONE : ssre_pkg::ST_IDLE;
                end
            end
            ssre_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    op_cmd_next    = s_tdata[1:0];
                    op_a_next      = s_tdata[11:2];
                    res_range_next = cur_range_reg;
                    res_reach_next = 1'b0;
                    res_trunc_next = 1'b0;
                    case (s_tdata[1:0])
                        ssre_pkg::CmdInit:
                        begin
                            cur_range_next = 10'(stamps_reg);
                            lsum_next      = 13'(stamps_reg);
                            clr_cnt_next   = '0;
                            clr_reply_next = 1'b1;
                            state_next     = ssre_pkg::ST_CLEAR;
                        end
                        ssre_pkg::CmdTest:
                        begin
                            t_next  = {1'b0, s_tdata[21:12]};
                            o_next  = '0;
                            c_next  = '0;
                            ca_next = '0;
                            if (tcount_reg == 7'd0)
                            begin
                                res_reach_next = 1'b1;
                                state_next     = ssre_pkg::ST_DONE;
                            end
                            else
                            begin
                                state_next = ssre_pkg::ST_TST_ISSUE;
                            end
                        end
                        default:
                        begin
                            d_next     = 4'd1;
                            wi_next    = '0;
                            found_next = 1'b0;
                            state_next = (s_tdata[11:2] == 10'd0) ? ssre_pkg::ST_DONE
                                                                  : ssre_pkg::ST_EXT_RD;
                        end
                    endcase
                end
            end
            ssre_pkg::ST_EXT_RD:
            begin
                state_next = ssre_pkg::ST_EXT_WR;
            end
            ssre_pkg::ST_EXT_WR:
            begin
                prev_next = src_word;
                if (d_reg == stamps_reg)
                begin
                    scan_vld_next  = 1'b1;
                    scan_word_next = ~new_word & scan_mask;
                    scan_idx_next  = wi_reg;
                end
                wi_next    = wi_reg + 4'd1;
                state_next = ssre_pkg::ST_EXT_RD;
                if (wi_reg == 4'(ssre_pkg::RowWords - 1))
                begin
                    if (d_reg == stamps_reg)
                    begin
                        state_next = ssre_pkg::ST_EXT_DRAIN;
                    end
                    else
                    begin
                        d_next = d_reg + 4'd1;
                    end
                end
            end
            ssre_pkg::ST_EXT_DRAIN:
            begin
                state_next = ssre_pkg::ST_EXT_RES;
            end
            ssre_pkg::ST_EXT_RES:
            begin
                res_range_next = found_reg ? (found_x_reg - 10'd1) : 10'(upper - 11'd1);
                res_trunc_next = (prod_ha >= 14'(ssre_pkg::RowBits));
                if (op_cmd_reg == ssre_pkg::CmdAdd)
                begin
                    cur_range_next = found_reg ? (found_x_reg - 10'd1) : 10'(upper - 11'd1);
                    if (prod_ha > 14'(lsum_reg))
                    begin
                        lsum_next = 13'(prod_ha);
                    end
                end
                state_next = ssre_pkg::ST_DONE;
            end
            ssre_pkg::ST_TST_ISSUE:
            begin
                if ((c_reg != 4'd0) && (ca_reg > 14'(t_reg)))
                begin
                    res_reach_next = 1'b0;
                    state_next     = ssre_pkg::ST_DONE;
                end
                else
                begin
                    chk_ok_next  = (17'(r_val) <= bound) && (r_val < 14'(ssre_pkg::RowBits));
                    chk_bit_next = r_val[5:0];
                    state_next   = ssre_pkg::ST_TST_CHECK;
                end
            end
            ssre_pkg::ST_TST_CHECK:
            begin
                if (chk_ok_reg && dst_rdata[chk_bit_reg])
                begin
                    if ((8'(o_reg) + 8'd1) == 8'(tcount_reg))
                    begin
                        res_reach_next = 1'b1;
                        state_next     = ssre_pkg::ST_DONE;
                    end
                    else
                    begin
                        o_next     = o_reg + 7'd1;
                        t_next     = t_reg + 11'd1;
                        c_next     = '0;
                        ca_next    = '0;
                        state_next = ssre_pkg::ST_TST_ISSUE;
                    end
                end
                else if (c_reg == stamps_reg)
                begin
                    res_reach_next = 1'b0;
                    state_next     = ssre_pkg::ST_DONE;
                end
                else
                begin
                    c_next     = c_reg + 4'd1;
                    ca_next    = ca_reg + 14'(op_a_reg);
                    state_next = ssre_pkg::ST_TST_ISSUE;
                end
            end
            ssre_pkg::ST_DONE:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next   = 1'b1;
                    out_range_next = res_range_reg;
                    out_reach_next = res_reach_reg;
                    out_trunc_next = res_trunc_reg;
                    state_next     = ssre_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssre_pkg::ST_IDLE;
            end
        endcase

        // Register writes; stamps restarts the table
        if (cfg_wr)
        begin
            if (paddr[2] == ssre_pkg::RegStamps)
            begin
                stamps_next    = stamps_wr;
                cur_range_next = 10'(stamps_wr);
                lsum_next      = 13'(stamps_wr);
                clr_cnt_next   = '0;
                clr_reply_next = 1'b0;
                state_next     = ssre_pkg::ST_CLEAR;
            end
            else
            begin
                tcount_next = pwdata[6:0];
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssre_pkg::ST_CLEAR;
            stamps_reg    <= 4'd4;
            tcount_reg    <= 7'd1;
            cur_range_reg <= 10'd4;
            lsum_reg      <= 13'd4;
            clr_cnt_reg   <= '0;
            clr_reply_reg <= 1'b0;
            scan_vld_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stamps_reg    <= stamps_next;
            tcount_reg    <= tcount_next;
            cur_range_reg <= cur_range_next;
            lsum_reg      <= lsum_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_reply_reg <= clr_reply_next;
            scan_vld_reg  <= scan_vld_next;
            found_reg     <= found_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_cmd_reg    <= op_cmd_next;
        op_a_reg      <= op_a_next;
        d_reg         <= d_next;
        wi_reg        <= wi_next;
        prev_reg      <= prev_next;
        scan_word_reg <= scan_word_next;
        scan_idx_reg  <= scan_idx_next;
        found_x_reg   <= found_x_next;
        t_reg         <= t_next;
        o_reg         <= o_next;
        c_reg         <= c_next;
        ca_reg        <= ca_next;
        chk_ok_reg    <= chk_ok_next;
        chk_bit_reg   <= chk_bit_next;
        res_range_reg <= res_range_next;
        res_reach_reg <= res_reach_next;
        res_trunc_reg <= res_trunc_next;
        out_range_reg <= out_range_next;
        out_reach_reg <= out_reach_next;
        out_trunc_reg <= out_trunc_next;
    end

endmodule

`default_nettype wire

// File: rtl/ssre_checker.sv
// Port-level checks of the stamp-sum reachability engine and their binding.
`timescale 1ns / 1ps
`default_nettype none

module ssre_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Take one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while busy");

    // Drop input while the table is rebuilt after a stamps write
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && !paddr[2] |=> !s_tready)
        else $error("input open during table rebuild");

    // Truncated only comes from add or peek, which never report reachable
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[10] && m_tdata[11]))
        else $error("reachable and truncated both set");

    // Keep pad bits clear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:12] == 4'd0))
        else $error("pad bits set");

endmodule

bind stamp_sum_reachability_engine_core ssre_checker u_ssre_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr)
);

`default_nettype wire

// File: bench/stamp_sum_reachability_engine_core_tb.sv
// Self-checking testbench of the stamp-sum reachability engine core.
`timescale 1ns / 1ps

module stamp_sum_reachability_engine_core_tb;

    localparam int CycleLimit = 6000000;

    typedef struct packed {
        logic       truncated;
        logic       reachable;
        logic [9:0] span;
    } stamp_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // cmd[1:0], denomination[11:2], first_sum[21:12]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // range[9:0], reachable[10], truncated[11]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state
    logic [ssre_pkg::RowBits-1:0] sum_rows [0:ssre_pkg::MaxStamps];
    int unsigned        h_stamps;
    int unsigned        tgt_count;
    int unsigned        stored_span;
    int unsigned        largest_sum;

    stamp_result_t expected_results [$];
    int unsigned   cycle_count;
    int unsigned   error_count;
    int unsigned   items_sent;
    int unsigned   results_seen;
    int unsigned   trunc_seen;
    int unsigned   reach_seen;
    bit            quiet;

    stamp_sum_reachability_engine_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Rebuild rows for basis {1}
    function automatic void init_basis();
        for (int d = 0; d <= ssre_pkg::MaxStamps; d++)
        begin
            sum_rows[d] = '0;
            if (d <= int'(h_stamps))
            begin
                for (int x = 0; x <= d; x++)
                begin
                    sum_rows[d][x] = 1'b1;
                end
            end
        end
        stored_span = h_stamps;
        largest_sum = h_stamps;
    endfunction

    function automatic bit sum_hit(input logic [ssre_pkg::RowBits-1:0] row,
                                   input int unsigned x);
        if (x >= ssre_pkg::RowBits)
        begin
            return 1'b0;
        end
        return row[x];
    endfunction

    function automatic bit target_reached(input int unsigned a, input int unsigned t);
        int unsigned r;
        int unsigned d;
        if (t <= largest_sum && sum_hit(sum_rows[h_stamps], t))
        begin
            return 1'b1;
        end
        for (int unsigned c = 1; c <= h_stamps; c++)
        begin
            if (c * a > t)
            begin
                break;
            end
            r = t - c * a;
            d = h_stamps - c;
            if (r <= d * largest_sum && sum_hit(sum_rows[d], r))
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Compute the result of one item and update the table
    function automatic stamp_result_t predict_stamp_item(input logic [1:0] cmd,
                                                          input int unsigned a,
                                                          input int unsigned first);
        stamp_result_t                res;
        logic [ssre_pkg::RowBits-1:0] ext [0:ssre_pkg::MaxStamps];
        int unsigned                  span;
        int unsigned                  upper;
        bit                           found;
        span = stored_span;
        res  = '0;
        if (cmd == ssre_pkg::CmdInit)
        begin
            init_basis();
            span = stored_span;
        end
        else if (cmd == ssre_pkg::CmdAdd || cmd == ssre_pkg::CmdPeek)
        begin
            if (a != 0)
            begin
                ext = sum_rows;
                for (int d = 1; d <= int'(h_stamps); d++)
                begin
                    ext[d] = ext[d] | (ext[d-1] << a);
                end
                upper = h_stamps * a + 1;
                if (upper > ssre_pkg::RowBits)
                begin
                    upper = ssre_pkg::RowBits;
                end
                span  = upper - 1;
                found = 1'b0;
                for (int unsigned x = stored_span + 1; x < upper && !found; x++)
                begin
                    if (!ext[h_stamps][x])
                    begin
                        span  = x - 1;
                        found = 1'b1;
                    end
                end
                res.truncated = (h_stamps * a >= ssre_pkg::RowBits);
                if (cmd == ssre_pkg::CmdAdd)
                begin
                    sum_rows    = ext;
                    stored_span = span;
                    if (h_stamps * a > largest_sum)
                    begin
                        largest_sum = h_stamps * a;
                    end
                end
            end
        end
        else
        begin
            res.reachable = 1'b1;
            for (int unsigned o = 0; o < tgt_count; o++)
            begin
                if (!target_reached(a, first + o))
                begin
                    res.reachable = 1'b0;
                    break;
                end
            end
        end
        res.span = (span > 1023) ? 10'd1023 : span[9:0];
        return res;
    endfunction

    // Cycle counter and timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result stall bursts
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            m_tready = 1'b1;
            if (!quiet && $urandom_range(0, 1) == 0)
            begin
                repeat ($urandom_range(1, 30)) @(negedge clk);
            end
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        stamp_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result %h", $time, m_tdata);
            end
            else
            begin
                want = expected_results.pop_front();
                trunc_seen += m_tdata[11];
                reach_seen += m_tdata[10];
                if (m_tdata[9:0] !== want.span)
                begin
                    error_count++;
                    $display("%0t: range expected %0d actual %0d", $time, want.span,
                             m_tdata[9:0]);
                end
                if (m_tdata[10] !== want.reachable)
                begin
                    error_count++;
                    $display("%0t: reachable expected %0b actual %0b", $time,
                             want.reachable, m_tdata[10]);
                end
                if (m_tdata[11] !== want.truncated)
                begin
                    error_count++;
                    $display("%0t: truncated expected %0b actual %0b", $time,
                             want.truncated, m_tdata[11]);
                end
            end
        end
    end

    // Send one item, with an optional idle burst first
    task automatic send_item(input logic [1:0] cmd, input int unsigned a,
                             input int unsigned first);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, first[9:0], a[9:0], cmd};
        forever
        begin
            @(posedge clk);
            if (s_tready)
            begin
                break;
            end
        end
        // Predict from the field bits that were actually driven
        expected_results.insert(expected_results.size(),
                                predict_stamp_item(cmd, a & 32'h3FF, first & 32'h3FF));
        items_sent++;
    endtask

    // Wait until every result is back and the block is idle
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    // APB write: setup then access
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (addr == 3'(4 * ssre_pkg::RegStamps))
        begin
            h_stamps = 32'(value[3:0]);
            if (h_stamps < 1)
            begin
                h_stamps = 1;
            end
            if (h_stamps > ssre_pkg::MaxStamps)
            begin
                h_stamps = ssre_pkg::MaxStamps;
            end
            init_basis();
        end
        else
        begin
            tgt_count = 32'(value[6:0]);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic test_directed();
        send_item(ssre_pkg::CmdPeek, 0, 0);
        send_item(ssre_pkg::CmdAdd, 0, 0);
        send_item(ssre_pkg::CmdTest, 0, 0);
        send_item(ssre_pkg::CmdPeek, 1023, 1023);
        send_item(ssre_pkg::CmdAdd, 2, 0);
        send_item(ssre_pkg::CmdAdd, 3, 0);
        send_item(ssre_pkg::CmdPeek, 5, 0);
        send_item(ssre_pkg::CmdTest, 3, 1023);
        send_item(ssre_pkg::CmdTest, 5, 13);
        send_item(ssre_pkg::CmdAdd, 1, 0);
        send_item(ssre_pkg::CmdAdd, 1023, 0);
        send_item(ssre_pkg::CmdTest, 1023, 1023);
        send_item(ssre_pkg::CmdInit, 1023, 1023);
        drain();
        write_reg(3'(4 * ssre_pkg::RegTcount), 32'd0);
        send_item(ssre_pkg::CmdTest, 7, 900);
        drain();
        write_reg(3'(4 * ssre_pkg::RegTcount), 32'd127);
        write_reg(3'(4 * ssre_pkg::RegStamps), 32'd15);
        send_item(ssre_pkg::CmdAdd, 128, 0);
        send_item(ssre_pkg::CmdTest, 128, 0);
        send_item(ssre_pkg::CmdTest, 128, 1000);
        drain();
        write_reg(3'(4 * ssre_pkg::RegStamps), 32'd0);
        send_item(ssre_pkg::CmdAdd, 1023, 0);
        send_item(ssre_pkg::CmdTest, 1023, 1000);
        send_item(ssre_pkg::CmdPeek, 512, 0);
        drain();
    endtask

    // One well-formed basis build with random peeks and tests, plus some noise
    task automatic run_basis(input int unsigned n_items);
        int unsigned a;
        int unsigned k;
        a = 1;
        send_item(ssre_pkg::CmdInit, $urandom_range(0, 1023), $urandom_range(0, 1023));
        for (int i = 1; i < int'(n_items); i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 10)
            begin
                send_item(2'($urandom_range(0, 3)), $urandom_range(0, 1023),
                          $urandom_range(0, 1023));
            end
            else if (k < 45)
            begin
                a = a + $urandom_range(1, stored_span + 1);
                if (a > 1023)
                begin
                    a = $urandom_range(1, 1023);
                end
                send_item(ssre_pkg::CmdAdd, a, 0);
            end
            else if (k < 60)
            begin
                send_item(ssre_pkg::CmdPeek, a + $urandom_range(1, stored_span + 1), 0);
            end
            else
            begin
                send_item(ssre_pkg::CmdTest, a + $urandom_range(0, 40),
                          (k < 90) ? $urandom_range(0, stored_span + 8)
                                   : $urandom_range(0, 1023));
            end
        end
    endtask

    task automatic test_random();
        int unsigned h_list [8] = '{1, 2, 3, 4, 5, 8, 0, 15};
        for (int p = 0; p < 8; p++)
        begin
            drain();
            write_reg(3'(4 * ssre_pkg::RegStamps), h_list[p]);
            write_reg(3'(4 * ssre_pkg::RegTcount),
                      (p == 2) ? 64 : (p == 5) ? 1 : $urandom_range(1, 64));
            if (p == 7)
            begin
                quiet = 1'b1;
            end
            for (int s = 0; s < 5; s++)
            begin
                run_basis($urandom_range(12, 30));
            end
        end
        drain();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        quiet       = 1'b0;
        cycle_count = 0;
        error_count = 0;
        items_sent  = 0;
        h_stamps    = 4;
        tgt_count   = 1;
        init_basis();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random();

        if (expected_results.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d results never arrived", $time, expected_results.size());
        end
        $display("Sent %0d items over 8 stamp settings; %0d results checked",
                 items_sent, results_seen);
        $display("Results with truncation: %0d, reach tests passed: %0d",
                 trunc_seen, reach_seen);
        if (error_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
